// ----- sv/dtc_sbm_pkg.sv -----
// ----------------------------------------------------------------------------
// DTC status byte manager package
// Shared types, command codes, status bit masks and stream layout constants.
// ----------------------------------------------------------------------------
package dtc_sbm_pkg;

    // Stream and configuration port widths
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 4;
    localparam int M_DATA_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // Number of enable conditions that are checked against the required mask
    localparam int COND_COUNT = 8;
    localparam logic [7:0] COND_LIMIT = 8'((9'd1 << COND_COUNT) - 9'd1);

    // Command codes carried in the input tuser
    localparam logic [3:0] FN_REPORT      = 4'd0;
    localparam logic [3:0] FN_CYCLE_END   = 4'd1;
    localparam logic [3:0] FN_RESET_STAT  = 4'd2;
    localparam logic [3:0] FN_RESET_MON   = 4'd3;
    localparam logic [3:0] FN_SET_AVAIL   = 4'd4;
    localparam logic [3:0] FN_SET_WIR     = 4'd5;
    localparam logic [3:0] FN_SET_COND    = 4'd6;
    localparam logic [3:0] FN_LOAD_MASK   = 4'd7;
    localparam logic [3:0] FN_SET_COUNTER = 4'd8;

    // Qualified report results
    localparam logic [1:0] QUAL_PASSED = 2'd0;
    localparam logic [1:0] QUAL_FAILED = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEALING_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIR_HEAL_EN = 2'd2;

    // Status byte bits
    localparam logic [7:0] ST_TF     = 8'h01;
    localparam logic [7:0] ST_TFTOC  = 8'h02;
    localparam logic [7:0] ST_PDTC   = 8'h04;
    localparam logic [7:0] ST_CDTC   = 8'h08;
    localparam logic [7:0] ST_TNCLC  = 8'h10;
    localparam logic [7:0] ST_TFSLC  = 8'h20;
    localparam logic [7:0] ST_TNCTOC = 8'h40;
    localparam logic [7:0] ST_WIR    = 8'h80;

    // Monitor bits
    localparam logic [1:0] MON_TF  = 2'b01;
    localparam logic [1:0] MON_TNC = 2'b10;

    // Table read address sources
    localparam logic [1:0] RD_SRC_PORT  = 2'd0;
    localparam logic [1:0] RD_SRC_SWEEP = 2'd1;
    localparam logic [1:0] RD_SRC_ITEM  = 2'd2;

    // One table entry per event
    typedef struct packed {
        logic       avail;
        logic [7:0] mask;
        logic [7:0] heal;
        logic [7:0] conf;
        logic [1:0] mon;
        logic [7:0] status;
    } entry_t;

    localparam entry_t RESET_ENTRY = '{
        avail:  1'b1,
        mask:   8'h00,
        heal:   8'h00,
        conf:   8'h00,
        mon:    MON_TNC,
        status: 8'h50
    };

    // Controller to datapath commands
    typedef struct packed {
        logic       latch;
        logic       rd_en;
        logic [1:0] rd_src;
        logic       sweep_clr;
        logic       sweep_inc;
        logic       sweep_wr;
        logic       exec;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sweep_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- sv/dtc_sbm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dtc_sbm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/dtc_sbm_ctrl.sv -----
// ----------------------------------------------------------------------------
// DTC status byte manager controller
// Sequences item intake, the operation-cycle sweep and the table update.
// ----------------------------------------------------------------------------
module dtc_sbm_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dtc_sbm_pkg::S_USER_W-1:0]    s_tuser,
    input  dtc_sbm_pkg::dp_stat_t               stat,
    output dtc_sbm_pkg::dp_cmd_t                cmd
);

    import dtc_sbm_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SW_RD = 3'd1;
    localparam logic [2:0] ST_SW_WR = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_EXEC  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Next state and command decode
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.rd_src    = RD_SRC_PORT;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch     = 1'b1;
                    cmd.rd_en     = 1'b1;
                    cmd.sweep_clr = 1'b1;
                    if (s_tuser == FN_CYCLE_END)
                    begin
                        state_next = ST_SW_RD;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_SW_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_SRC_SWEEP;
                state_next = ST_SW_WR;
            end
            ST_SW_WR:
            begin
                cmd.sweep_wr = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    cmd.sweep_inc = 1'b1;
                    state_next    = ST_SW_RD;
                end
            end
            ST_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_SRC_ITEM;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/dtc_sbm_dp.sv -----
// ----------------------------------------------------------------------------
// DTC status byte manager datapath
// Holds the event table, configuration, conditions and the output register.
// ----------------------------------------------------------------------------
module dtc_sbm_dp #(
    parameter int NUM_EVENTS = 32,
    parameter int ADDR_W     = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dtc_sbm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dtc_sbm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [dtc_sbm_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic [dtc_sbm_pkg::S_USER_W-1:0]    s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dtc_sbm_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                                m_tuser,
    input  dtc_sbm_pkg::dp_cmd_t                cmd,
    output dtc_sbm_pkg::dp_stat_t               stat
);

    import dtc_sbm_pkg::*;

    localparam int ENTRY_W = $bits(entry_t);

    // Latched item
    logic [3:0]        func_reg;
    logic [7:0]        id_reg;
    logic [1:0]        qual_reg;
    logic              flag_reg;
    logic [2:0]        cidx_reg;
    logic [7:0]        cmask_reg;
    logic [7:0]        cval_reg;

    // Configuration and global conditions
    logic [7:0]        cthr_reg;
    logic [7:0]        hthr_reg;
    logic              heal_en_reg;
    logic [7:0]        cond_met_reg;
    logic [7:0]        cond_met_next;

    // Table control
    logic [NUM_EVENTS-1:0] vbits_reg;
    logic              ent_valid_reg;
    logic [ADDR_W-1:0] sweep_idx_reg;
    logic [ADDR_W-1:0] port_idx;
    logic [ADDR_W-1:0] item_idx;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic              we;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;
    logic              port_valid;
    logic              item_valid;

    // Execution results
    entry_t            ent;
    entry_t            ent_new;
    entry_t            ent_sweep;
    logic              ok;
    logic              store;
    logic              ent_wr;
    logic              conds_ok;
    logic [7:0]        conf_upd;
    logic [7:0]        heal_upd;

    // Output register
    logic              m_tvalid_reg;
    logic              ok_reg;
    logic [7:0]        out_status_reg;
    logic [1:0]        out_mon_reg;
    logic              out_store_reg;

    // Event index from the one-based id
    assign port_valid = (s_tdata[7:0] != 8'd0) && (s_tdata[7:0] <= 8'(NUM_EVENTS));
    assign item_valid = (id_reg != 8'd0) && (id_reg <= 8'(NUM_EVENTS));
    assign port_idx   = port_valid ? ADDR_W'(s_tdata[7:0] - 8'd1) : '0;
    assign item_idx   = item_valid ? ADDR_W'(id_reg - 8'd1) : '0;

    // Read address selection
    always_comb
    begin
        case (cmd.rd_src)
            RD_SRC_PORT:  raddr = port_idx;
            RD_SRC_SWEEP: raddr = sweep_idx_reg;
            RD_SRC_ITEM:  raddr = item_idx;
            default:      raddr = item_idx;
        endcase
    end

    // Entries never written read as their reset value
    assign ent = ent_valid_reg ? entry_t'(rdata) : RESET_ENTRY;

    // Operation-cycle end update of one entry
    always_comb
    begin
        ent_sweep        = ent;
        ent_sweep.status = (ent.status & ~ST_TFTOC) | ST_TNCTOC;
    end

    assign conds_ok = ((ent.mask & COND_LIMIT & ~cond_met_reg) == 8'd0);
    assign conf_upd = (ent.conf < cthr_reg) ? ent.conf + 8'd1 : ent.conf;
    assign heal_upd = (ent.heal < hthr_reg) ? ent.heal + 8'd1 : ent.heal;

    // Command execution on the addressed entry
    always_comb
    begin
        ent_new       = ent;
        ok            = 1'b0;
        store         = 1'b0;
        ent_wr        = 1'b0;
        cond_met_next = cond_met_reg;
        case (func_reg)
            FN_REPORT:
            begin
                if (item_valid && ent.avail && conds_ok)
                begin
                    ok     = 1'b1;
                    ent_wr = 1'b1;
                    if (qual_reg == QUAL_FAILED)
                    begin
                        ent_new.status = (ent.status | ST_TF | ST_TFTOC | ST_TFSLC)
                                         & ~(ST_TNCTOC | ST_TNCLC);
                        ent_new.mon    = MON_TF;
                        ent_new.conf   = conf_upd;
                        ent_new.heal   = 8'd0;
                        if (conf_upd >= cthr_reg)
                        begin
                            ent_new.status = ent_new.status | ST_PDTC | ST_CDTC;
                        end
                        store = ((ent_new.status & ST_CDTC) != 8'd0);
                    end
                    else if (qual_reg == QUAL_PASSED)
                    begin
                        ent_new.status = ent.status & ~(ST_TF | ST_TNCTOC);
                        ent_new.mon    = 2'b00;
                        ent_new.conf   = 8'd0;
                        if (heal_en_reg)
                        begin
                            ent_new.heal = heal_upd;
                            if (heal_upd >= hthr_reg)
                            begin
                                ent_new.status = ent_new.status & ~ST_WIR;
                            end
                        end
                    end
                end
            end
            FN_CYCLE_END:
            begin
                // The sweep has already updated the table
                ok = 1'b1;
            end
            FN_RESET_STAT:
            begin
                if (item_valid)
                begin
                    ok             = 1'b1;
                    ent_wr         = 1'b1;
                    ent_new.status = ent.status & ~ST_TF;
                end
            end
            FN_RESET_MON:
            begin
                if (item_valid)
                begin
                    ok          = 1'b1;
                    ent_wr      = 1'b1;
                    ent_new.mon = MON_TNC;
                end
            end
            FN_SET_AVAIL:
            begin
                if (item_valid)
                begin
                    ok            = 1'b1;
                    ent_wr        = 1'b1;
                    ent_new.avail = flag_reg;
                end
            end
            FN_SET_WIR:
            begin
                if (item_valid)
                begin
                    ok     = 1'b1;
                    ent_wr = 1'b1;
                    if (flag_reg)
                    begin
                        ent_new.status = ent.status | ST_WIR;
                    end
                    else
                    begin
                        ent_new.status = ent.status & ~ST_WIR;
                    end
                end
            end
            FN_SET_COND:
            begin
                if ({1'b0, cidx_reg} < 4'(COND_COUNT))
                begin
                    ok                      = 1'b1;
                    cond_met_next[cidx_reg] = flag_reg;
                end
            end
            FN_LOAD_MASK:
            begin
                if (item_valid)
                begin
                    ok           = 1'b1;
                    ent_wr       = 1'b1;
                    ent_new.mask = cmask_reg;
                end
            end
            FN_SET_COUNTER:
            begin
                if (item_valid)
                begin
                    ok           = 1'b1;
                    ent_wr       = 1'b1;
                    ent_new.conf = cval_reg;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Table write port selection
    assign we    = cmd.sweep_wr || (cmd.exec && ent_wr);
    assign waddr = cmd.sweep_wr ? sweep_idx_reg : item_idx;
    assign wdata = cmd.sweep_wr ? ENTRY_W'(ent_sweep) : ENTRY_W'(ent_new);

    dtc_sbm_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (NUM_EVENTS),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Written-entry flags and the read-side copy of the flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbits_reg     <= '0;
            ent_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vbits_reg[waddr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                ent_valid_reg <= vbits_reg[raddr];
            end
        end
    end

    // Sweep index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_idx_reg <= '0;
        end
        else if (cmd.sweep_clr)
        begin
            sweep_idx_reg <= '0;
        end
        else if (cmd.sweep_inc)
        begin
            sweep_idx_reg <= sweep_idx_reg + ADDR_W'(1);
        end
    end

    assign stat.sweep_last = (sweep_idx_reg == ADDR_W'(NUM_EVENTS - 1));
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg  <= s_tuser;
            id_reg    <= s_tdata[7:0];
            qual_reg  <= s_tdata[9:8];
            flag_reg  <= s_tdata[10];
            cidx_reg  <= s_tdata[13:11];
            cmask_reg <= s_tdata[21:14];
            cval_reg  <= s_tdata[29:22];
        end
    end

    // Configuration registers and enable conditions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cthr_reg     <= 8'd1;
            hthr_reg     <= 8'd1;
            heal_en_reg  <= 1'b1;
            cond_met_reg <= 8'hFF;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CONFIRM_THR: cthr_reg    <= cfg_data;
                    CFG_HEALING_THR: hthr_reg    <= cfg_data;
                    CFG_WIR_HEAL_EN: heal_en_reg <= cfg_data[0];
                    default:         cthr_reg    <= cthr_reg;
                endcase
            end
            if (cmd.exec)
            begin
                cond_met_reg <= cond_met_next;
            end
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ok_reg         <= ok;
            out_status_reg <= item_valid ? ent_new.status : 8'd0;
            out_mon_reg    <= item_valid ? ent_new.mon : 2'b00;
            out_store_reg  <= store;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = ok_reg;
    assign m_tdata  = {5'd0, out_store_reg, out_mon_reg, out_status_reg};

endmodule

// ----- sv/dtc_status_byte_manager.sv -----
// ----------------------------------------------------------------------------
// DTC status byte manager
// Per-event diagnostic status table with report handling and cycle-end sweep.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer condition      Contents
//  cfg       in         cfg_we high             register cfg_index <= cfg_data
//  s_*       in         s_tvalid and s_tready   one command
//  m_*       out        m_tvalid and m_tready   one result per command
//
// A command reads the table at the transfer and updates it in ST_EXEC, when
// the result is loaded into the output register.
// Operation-cycle end walks the table, reading each event in ST_SW_RD and
// writing it back in ST_SW_WR, then rereads the addressed entry in ST_RD.
// After reset every event reads as its reset entry; no clearing pass is run.
// A stalled output holds the update until the output register is free.
// ----------------------------------------------------------------------------
module dtc_status_byte_manager #(
    parameter int NUM_EVENTS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [dtc_sbm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dtc_sbm_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Command stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // event_id[7:0], qual[9:8], flag_value[10], cond_index[13:11],
    // cond_mask[21:14], counter_value[29:22], zero fill
    input  logic [dtc_sbm_pkg::S_DATA_W-1:0]    s_tdata,
    // func[3:0]
    input  logic [dtc_sbm_pkg::S_USER_W-1:0]    s_tuser,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status_byte[7:0], monitor_bits[9:8], store_request[10], zero fill
    output logic [dtc_sbm_pkg::M_DATA_W-1:0]    m_tdata,
    // ok[0]
    output logic                                m_tuser
);

    import dtc_sbm_pkg::*;

    localparam int ADDR_W = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dtc_sbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    dtc_sbm_dp #(
        .NUM_EVENTS (NUM_EVENTS),
        .ADDR_W     (ADDR_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
